@@ hw/rtl/sqtu_pkg.sv @@
// Shared types, constants and reset values of the SARSA Q-table update core.
package sqtu_pkg;

  // Fixed field widths
  localparam int unsigned STATE_W  = 4;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Default geometry
  localparam int unsigned DEF_STATE_COUNT  = 16;
  localparam int unsigned DEF_ACTION_COUNT = 4;

  // Generator constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // Register reset values
  localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RST   = 16'd62259;
  localparam logic [31:0]       EXPLORE_RST    = 32'd214748365;
  localparam logic [31:0]       SEED_RST       = 32'd42;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_START = 2'd3;

  // Configuration as seen by the datapath and the generator
  typedef struct packed {
    logic [RATE_W-1:0] learn_rate;
    logic [RATE_W-1:0] discount;
    logic [31:0]       explore_threshold;
    logic              seed_load;
    logic [31:0]       seed_value;
  } cfg_t;

endpackage

@@ hw/rtl/sqtu_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module sqtu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sqtu_cfg_regs.sv @@
// Configuration register file: decodes writes and holds alpha, gamma and threshold.
module sqtu_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sqtu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sqtu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output sqtu_pkg::cfg_t                   cfg_o
);
  import sqtu_pkg::*;

  logic [RATE_W-1:0] learn_rate_q, learn_rate_d;
  logic [RATE_W-1:0] discount_q, discount_d;
  logic [31:0]       explore_q, explore_d;
  logic              seed_load;

  // Write decode
  always_comb begin
    learn_rate_d = learn_rate_q;
    discount_d   = discount_q;
    explore_d    = explore_q;
    seed_load    = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEARN_RATE: learn_rate_d = cfg_data_i[RATE_W-1:0];
        CFG_DISCOUNT:   discount_d   = cfg_data_i[RATE_W-1:0];
        CFG_EXPLORE:    explore_d    = cfg_data_i[31:0];
        CFG_SEED_START: seed_load    = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q <= LEARN_RATE_RST;
      discount_q   <= DISCOUNT_RST;
      explore_q    <= EXPLORE_RST;
    end else begin
      learn_rate_q <= learn_rate_d;
      discount_q   <= discount_d;
      explore_q    <= explore_d;
    end
  end

  assign cfg_o.learn_rate        = learn_rate_q;
  assign cfg_o.discount          = discount_q;
  assign cfg_o.explore_threshold = explore_q;
  assign cfg_o.seed_load         = seed_load;
  assign cfg_o.seed_value        = cfg_data_i[31:0];

endmodule

@@ hw/rtl/sqtu_lcg.sv @@
// 32-bit linear congruential generator with seed load from the register file.
module sqtu_lcg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sqtu_pkg::cfg_t cfg_i,
  input  logic           step_i,
  output logic [31:0]    seed_o
);
  import sqtu_pkg::*;

  logic [31:0] seed_q, seed_d;

  // Seed load takes priority; the user must change config only while idle, the block itself does not enforce it
  always_comb begin
    seed_d = seed_q;
    if (cfg_i.seed_load) begin
      seed_d = cfg_i.seed_value;
    end else if (step_i) begin
      seed_d = seed_q * LCG_MUL + LCG_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RST;
    end else begin
      seed_q <= seed_d;
    end
  end

  assign seed_o = seed_q;

endmodule

@@ hw/rtl/sarsa_q_table_update_core.sv @@
// Top level of the SARSA Q-table update core: sequencer, table and update arithmetic.
//
// After reset the core clears the Q table, one entry a cycle, with busy high. An item is
// taken when start is high and busy is low. A greedy item keeps busy high while the row of
// the following state is scanned through the single read port of the table, an exploring
// item while one random entry of that row is read; then come two registered multiplies
// and the write-back of the updated entry. The result strobe follows in the next cycle,
// when busy is already low and the next item can be taken. Results are shown for one
// cycle on result_valid_o and cannot be held off. Configuration writes complete at once.
module sarsa_q_table_update_core #(
  parameter int unsigned STATE_COUNT  = sqtu_pkg::DEF_STATE_COUNT,
  parameter int unsigned ACTION_COUNT = sqtu_pkg::DEF_ACTION_COUNT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [sqtu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic       [sqtu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                                  start,
  output logic                                  busy,
  input  logic          [sqtu_pkg::STATE_W-1:0] cur_state_i,
  input  logic         [sqtu_pkg::ACTION_W-1:0] taken_action_i,
  input  logic signed   [sqtu_pkg::VALUE_W-1:0] reward_value_i,
  input  logic          [sqtu_pkg::STATE_W-1:0] following_state_i,
  output logic                                  result_valid_o,
  output logic signed   [sqtu_pkg::VALUE_W-1:0] updated_value_o,
  output logic         [sqtu_pkg::ACTION_W-1:0] chosen_next_action_o,
  output logic                                  explored_o
);
  import sqtu_pkg::*;

  localparam int unsigned DEPTH = STATE_COUNT * ACTION_COUNT;
  localparam int unsigned TW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(STATE_COUNT);
  localparam int unsigned AW    = $clog2(ACTION_COUNT);
  localparam int unsigned CW    = $clog2(ACTION_COUNT + 1);
  localparam logic [TW-1:0] AC_T      = TW'(ACTION_COUNT);
  localparam logic [TW-1:0] LAST_ADDR = TW'(DEPTH - 1);

  // Sequencer codes
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_RAND   = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_READN  = 4'd5;
  localparam logic [3:0] S_READC  = 4'd6;
  localparam logic [3:0] S_MULG   = 4'd7;
  localparam logic [3:0] S_DELTA  = 4'd8;
  localparam logic [3:0] S_MULD   = 4'd9;
  localparam logic [3:0] S_WB     = 4'd10;

  function automatic logic [TW-1:0] entry_addr(input logic [SW-1:0] st,
                                               input logic [AW-1:0] ac);
    return TW'(st) * AC_T + TW'(ac);
  endfunction

  cfg_t        cfg;
  logic [31:0] seed;
  logic        lcg_step;

  logic [3:0]  state_q, state_d;
  logic [TW-1:0] clr_q, clr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] s_q, s_d, ns_q, ns_d;
  logic [AW-1:0] a_q, a_d, na_q, na_d;
  logic signed [31:0] r_q, r_d;
  logic        expl_q, expl_d;
  logic signed [31:0] next_q_q, next_q_d;
  logic signed [31:0] cur_q_q, cur_q_d;
  logic signed [32:0] g_q, g_d;
  logic signed [33:0] delta_q, delta_d;
  logic signed [34:0] dq_q, dq_d;

  logic        out_valid_q, out_valid_d;
  logic signed [31:0] out_value_q, out_value_d;
  logic [AW-1:0] out_na_q, out_na_d;
  logic        out_expl_q, out_expl_d;

  logic        ram_we;
  logic [TW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  logic        accept;
  logic [31:0] s_ext, s_cl, a_ext, a_cl, ns_ext, ns_cl;
  logic [63:0] rnd_prod;
  logic [31:0] rnd_hi, rnd_cl;
  logic [CW-1:0] k_prev;
  logic signed [48:0] g_prod, g_rnd;
  logic signed [50:0] d_prod, d_rnd;
  logic signed [36:0] upd;
  logic signed [31:0] upd_sat;
  logic [31:0] na_ext;

  sqtu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sqtu_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (lcg_step),
    .seed_o (seed)
  );

  sqtu_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Index clamping
  assign s_ext  = 32'(cur_state_i);
  assign s_cl   = (s_ext >= 32'(STATE_COUNT)) ? 32'(STATE_COUNT - 1) : s_ext;
  assign a_ext  = 32'(taken_action_i);
  assign a_cl   = (a_ext >= 32'(ACTION_COUNT)) ? 32'(ACTION_COUNT - 1) : a_ext;
  assign ns_ext = 32'(following_state_i);
  assign ns_cl  = (ns_ext >= 32'(STATE_COUNT)) ? 32'(STATE_COUNT - 1) : ns_ext;

  // Random action from the top of the second generator value
  assign rnd_prod = 64'(seed) * 64'(ACTION_COUNT);
  assign rnd_hi   = rnd_prod[63:32];
  assign rnd_cl   = (rnd_hi >= 32'(ACTION_COUNT)) ? 32'(ACTION_COUNT - 1) : rnd_hi;

  assign k_prev = cnt_q - CW'(1);

  // g = round(gamma * Q[s'][a'])
  assign g_prod = 49'($signed({1'b0, cfg.discount})) * 49'(next_q_q);
  assign g_rnd  = g_prod + 49'sd32768;

  // d = round(alpha * delta)
  assign d_prod = 51'($signed({1'b0, cfg.learn_rate})) * 51'(delta_q);
  assign d_rnd  = d_prod + 51'sd32768;

  // Saturating update
  assign upd = 37'(cur_q_q) + 37'(dq_q);
  always_comb begin
    if (upd > 37'sd2147483647) begin
      upd_sat = 32'sh7fffffff;
    end else if (upd < -37'sd2147483648) begin
      upd_sat = 32'sh80000000;
    end else begin
      upd_sat = upd[31:0];
    end
  end

  // Table read address
  always_comb begin
    unique case (state_q)
      S_SCAN:  ram_raddr = entry_addr(ns_q, cnt_q[AW-1:0]);
      S_READN: ram_raddr = entry_addr(ns_q, na_q);
      S_READC: ram_raddr = entry_addr(s_q, a_q);
      default: ram_raddr = '0;
    endcase
  end

  // Table write: clearing pass or write-back
  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WB);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : entry_addr(s_q, a_q);
  assign ram_wdata = (state_q == S_CLEAR) ? 32'd0 : upd_sat;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    a_d         = a_q;
    ns_d        = ns_q;
    na_d        = na_q;
    r_d         = r_q;
    expl_d      = expl_q;
    next_q_d    = next_q_q;
    cur_q_d     = cur_q_q;
    g_d         = g_q;
    delta_d     = delta_q;
    dq_d        = dq_q;
    out_valid_d = 1'b0;
    out_value_d = out_value_q;
    out_na_d    = out_na_q;
    out_expl_d  = out_expl_q;
    lcg_step    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + TW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          s_d      = s_cl[SW-1:0];
          a_d      = a_cl[AW-1:0];
          ns_d     = ns_cl[SW-1:0];
          r_d      = reward_value_i;
          lcg_step = 1'b1;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_d = '0;
        if (seed < cfg.explore_threshold) begin
          expl_d   = 1'b1;
          lcg_step = 1'b1;
          state_d  = S_RAND;
        end else begin
          expl_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_RAND: begin
        na_d    = rnd_cl[AW-1:0];
        state_d = S_READN;
      end
      S_SCAN: begin
        // data arriving now belongs to the read issued in the previous cycle
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0) begin
          if ((cnt_q == CW'(1)) || ($signed(ram_rdata) > next_q_q)) begin
            next_q_d = $signed(ram_rdata);
            na_d     = k_prev[AW-1:0];
          end
        end
        if (cnt_q == CW'(ACTION_COUNT)) begin
          state_d = S_READC;
        end
      end
      S_READN: begin
        state_d = S_READC;
      end
      S_READC: begin
        if (expl_q) begin
          next_q_d = $signed(ram_rdata);
        end
        state_d = S_MULG;
      end
      S_MULG: begin
        cur_q_d = $signed(ram_rdata);
        g_d     = g_rnd[48:16];
        state_d = S_DELTA;
      end
      S_DELTA: begin
        delta_d = 34'(r_q) + 34'(g_q) - 34'(cur_q_q);
        state_d = S_MULD;
      end
      S_MULD: begin
        dq_d    = d_rnd[50:16];
        state_d = S_WB;
      end
      S_WB: begin
        out_valid_d = 1'b1;
        out_value_d = upd_sat;
        out_na_d    = na_q;
        out_expl_d  = expl_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    a_q         <= a_d;
    ns_q        <= ns_d;
    na_q        <= na_d;
    r_q         <= r_d;
    expl_q      <= expl_d;
    next_q_q    <= next_q_d;
    cur_q_q     <= cur_q_d;
    g_q         <= g_d;
    delta_q     <= delta_d;
    dq_q        <= dq_d;
    out_value_q <= out_value_d;
    out_na_q    <= out_na_d;
    out_expl_q  <= out_expl_d;
  end

  assign na_ext               = 32'(out_na_q);
  assign result_valid_o       = out_valid_q;
  assign updated_value_o      = out_value_q;
  assign chosen_next_action_o = na_ext[ACTION_W-1:0];
  assign explored_o           = out_expl_q;

  // Checks
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_strobe_after_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_WB))
    else $error("result strobe without write-back");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken without going busy");

  a_write_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_WB))
    else $error("table written outside clear or write-back");

endmodule

@@ tb/sqtu_checker.sv @@
// Checker for the SARSA Q-table update core: predicts every update and compares the results.
module sqtu_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sqtu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sqtu_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [sqtu_pkg::STATE_W-1:0]         cur_state_i,
  input  logic [sqtu_pkg::ACTION_W-1:0]        taken_action_i,
  input  logic signed [sqtu_pkg::VALUE_W-1:0]  reward_value_i,
  input  logic [sqtu_pkg::STATE_W-1:0]         following_state_i,
  input  logic                                 result_valid_o,
  input  logic signed [sqtu_pkg::VALUE_W-1:0]  updated_value_o,
  input  logic [sqtu_pkg::ACTION_W-1:0]        chosen_next_action_o,
  input  logic                                 explored_o,
  output int                                   fail_count,
  output int                                   pending_count
);
  import sqtu_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEF_STATE_COUNT * DEF_ACTION_COUNT;
  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ACTION_W-1:0]       next_action;
    logic                      explored;
  } q_update_t;

  // Shadow of the core's registers, table and generator
  logic [RATE_W-1:0]         alpha_q;
  logic [RATE_W-1:0]         gamma_q;
  logic [31:0]               explore_thr_q;
  logic [31:0]               lcg_q;
  logic signed [VALUE_W-1:0] q_table [TABLE_DEPTH];

  q_update_t expected_updates [$];
  q_update_t oldest;

  function automatic logic [31:0] lcg_advance();
    lcg_q = lcg_q * LCG_MUL + LCG_ADD;
    return lcg_q;
  endfunction

  // Q16.16 product back to integer scale, nearest with ties upwards
  function automatic longint round_q16(longint prod);
    return (prod + 64'sd32768) >>> 16;
  endfunction

  // One SARSA step: choose a', update Q[s][a] and return what the core should show
  function automatic q_update_t apply_experience(logic [STATE_W-1:0] s,
                                                 logic [ACTION_W-1:0] a,
                                                 logic signed [VALUE_W-1:0] r,
                                                 logic [STATE_W-1:0] ns);
    int unsigned               row;
    int unsigned               cur_idx;
    logic [31:0]               draw;
    logic [ACTION_W-1:0]       best_a;
    logic signed [VALUE_W-1:0] best_q;
    longint                    next_q;
    longint                    cur_q;
    longint                    disc_term;
    longint                    td_error;
    longint                    new_q;
    q_update_t                 res;
    row     = int'(ns) * DEF_ACTION_COUNT;
    cur_idx = int'(s) * DEF_ACTION_COUNT + int'(a);
    if (lcg_advance() < explore_thr_q) begin
      // explore: top bits of a second draw
      draw   = lcg_advance();
      best_a = draw[31:30];
      res.explored = 1'b1;
    end else begin
      // greedy: strict compare so the lowest index wins a tie
      best_a = '0;
      best_q = q_table[row];
      for (int k = 1; k < DEF_ACTION_COUNT; k++) begin
        if (q_table[row + k] > best_q) begin
          best_q = q_table[row + k];
          best_a = ACTION_W'(k);
        end
      end
      res.explored = 1'b0;
    end
    next_q    = q_table[row + int'(best_a)];
    cur_q     = q_table[cur_idx];
    disc_term = round_q16(longint'(gamma_q) * next_q);
    td_error  = longint'(r) + disc_term - cur_q;
    new_q     = cur_q + round_q16(longint'(alpha_q) * td_error);
    if (new_q > Q_MAX) new_q = Q_MAX;
    if (new_q < Q_MIN) new_q = Q_MIN;
    q_table[cur_idx] = new_q[VALUE_W-1:0];
    res.value       = new_q[VALUE_W-1:0];
    res.next_action = best_a;
    return res;
  endfunction

  // Results first, then register writes, then the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q       = LEARN_RATE_RST;
      gamma_q       = DISCOUNT_RST;
      explore_thr_q = EXPLORE_RST;
      lcg_q         = SEED_RST;
      for (int i = 0; i < TABLE_DEPTH; i++) q_table[i] = '0;
      expected_updates.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (result_valid_o === 1'b1) begin
        if (expected_updates.size() == 0) begin
          $error("updated_value: no result expected, got %0d", updated_value_o);
          fail_count++;
        end else begin
          oldest = expected_updates.pop_front();
          if (updated_value_o !== oldest.value) begin
            $error("updated_value: expected %0d, got %0d", oldest.value, updated_value_o);
            fail_count++;
          end
          if (chosen_next_action_o !== oldest.next_action) begin
            $error("chosen_next_action: expected %0d, got %0d",
                   oldest.next_action, chosen_next_action_o);
            fail_count++;
          end
          if (explored_o !== oldest.explored) begin
            $error("explored: expected %0d, got %0d", oldest.explored, explored_o);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEARN_RATE: alpha_q       = cfg_data_i[RATE_W-1:0];
          CFG_DISCOUNT:   gamma_q       = cfg_data_i[RATE_W-1:0];
          CFG_EXPLORE:    explore_thr_q = cfg_data_i[31:0];
          CFG_SEED_START: lcg_q         = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_updates.push_back(apply_experience(cur_state_i, taken_action_i,
                                                    reward_value_i, following_state_i));
      end
      pending_count = expected_updates.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top of the SARSA Q-table update core: clock, reset, stimulus and verdict.
module tb;
  import sqtu_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam logic signed [VALUE_W-1:0] R_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] R_MIN = 32'sh8000_0000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [STATE_W-1:0]        cur_state_i = '0;
  logic [ACTION_W-1:0]       taken_action_i = '0;
  logic signed [VALUE_W-1:0] reward_value_i = '0;
  logic [STATE_W-1:0]        following_state_i = '0;
  logic                      result_valid_o;
  logic signed [VALUE_W-1:0] updated_value_o;
  logic [ACTION_W-1:0]       chosen_next_action_o;
  logic                      explored_o;
  int                        fail_count;
  int                        pending_count;
  int                        cycle_count = 0;
  bit                        no_idle = 1'b0;

  sarsa_q_table_update_core i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .start                (start),
    .busy                 (busy),
    .cur_state_i          (cur_state_i),
    .taken_action_i       (taken_action_i),
    .reward_value_i       (reward_value_i),
    .following_state_i    (following_state_i),
    .result_valid_o       (result_valid_o),
    .updated_value_o      (updated_value_o),
    .chosen_next_action_o (chosen_next_action_o),
    .explored_o           (explored_o)
  );

  sqtu_checker i_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .start                (start),
    .busy                 (busy),
    .cur_state_i          (cur_state_i),
    .taken_action_i       (taken_action_i),
    .reward_value_i       (reward_value_i),
    .following_state_i    (following_state_i),
    .result_valid_o       (result_valid_o),
    .updated_value_o      (updated_value_o),
    .chosen_next_action_o (chosen_next_action_o),
    .explored_o           (explored_o),
    .fail_count           (fail_count),
    .pending_count        (pending_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Idle for a random gap with noise on the fields, then hold one item until taken
  task automatic issue_experience(logic [STATE_W-1:0] s, logic [ACTION_W-1:0] a,
                                  logic signed [VALUE_W-1:0] r, logic [STATE_W-1:0] ns);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      start             <= 1'b0;
      cur_state_i       <= STATE_W'($urandom());
      taken_action_i    <= ACTION_W'($urandom());
      reward_value_i    <= $urandom();
      following_state_i <= STATE_W'($urandom());
    end
    @(negedge clk_i);
    start             <= 1'b1;
    cur_state_i       <= s;
    taken_action_i    <= a;
    reward_value_i    <= r;
    following_state_i <= ns;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and wait until every expected result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [RATE_W-1:0] pick_rate(logic [RATE_W-1:0] rst_val);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return rst_val;
      default: return RATE_W'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return EXPLORE_RST;
      3:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Rewards: mostly small, some wide, a few at the extremes
  function automatic logic signed [VALUE_W-1:0] pick_reward();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $signed(32'($urandom_range(0, 1 << 19))) - 32'sd262144;
    if (pick < 85) return $signed({{8{$urandom_range(0, 1) == 1}}, 24'($urandom())});
    if (pick < 95) return $urandom();
    return (pick < 97) ? R_MAX : R_MIN;
  endfunction

  initial begin
    logic [STATE_W-1:0]  s;
    logic [ACTION_W-1:0] a;
    logic [STATE_W-1:0]  ns;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    // let the table clearing pass finish
    @(negedge clk_i);
    while (busy) @(negedge clk_i);

    // Reset configuration: field extremes, zero row ties
    issue_experience(4'd0, 2'd0, R_MAX, 4'd15);
    issue_experience(4'd15, 2'd3, R_MIN, 4'd0);
    issue_experience(4'd5, 2'd2, 32'sd0, 4'd5);
    issue_experience(4'd5, 2'd1, -32'sd1, 4'd5);
    issue_experience(4'd10, 2'd0, 32'sd65536, 4'd10);
    wait_drained();

    // Greedy only, alpha and gamma near one: drive entries into saturation
    write_register(CFG_LEARN_RATE, 32'hABCD_FFFF);
    write_register(CFG_DISCOUNT, 32'h0000_FFFF);
    write_register(CFG_EXPLORE, 32'h0000_0000);
    write_register(CFG_SEED_START, 32'hFFFF_FFFF);
    // same entry read as current and next once Q[3][1] leads its row
    repeat (4) issue_experience(4'd3, 2'd1, R_MAX, 4'd3);
    for (int k = 0; k < 4; k++) issue_experience(4'd6, ACTION_W'(k), R_MIN, 4'd6);
    issue_experience(4'd6, 2'd3, R_MIN, 4'd6);
    wait_drained();

    // Always explore, no learning
    write_register(CFG_LEARN_RATE, 32'h0000_0000);
    write_register(CFG_DISCOUNT, 32'h0000_0000);
    write_register(CFG_EXPLORE, 32'hFFFF_FFFF);
    write_register(CFG_SEED_START, 32'h0000_0000);
    issue_experience(4'd7, 2'd2, R_MAX, 4'd8);
    issue_experience(4'd8, 2'd3, R_MIN, 4'd7);
    issue_experience(4'd0, 2'd0, 32'sd0, 4'd0);
    wait_drained();

    // Random phases, each under a fresh configuration
    for (int p = 0; p < RAND_PHASES; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_register(CFG_LEARN_RATE, {16'($urandom()), pick_rate(LEARN_RATE_RST)});
      write_register(CFG_DISCOUNT, {16'($urandom()), pick_rate(DISCOUNT_RST)});
      write_register(CFG_EXPLORE, pick_threshold());
      if ($urandom_range(0, 1) == 1) write_register(CFG_SEED_START, $urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // half the items stay in a few states so updates build on each other
        if ($urandom_range(0, 1) == 1) begin
          s  = STATE_W'($urandom_range(0, 3));
          ns = STATE_W'($urandom_range(0, 3));
        end else begin
          s  = STATE_W'($urandom());
          ns = STATE_W'($urandom());
        end
        if ($urandom_range(0, 9) == 0) ns = s;
        a = ACTION_W'($urandom());
        issue_experience(s, a, pick_reward(), ns);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
